@@ src/kpir_pkg.sv @@
package kpir_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_BIT  = 1'b1;

    // Frame layout: start bit, seven data bits, parity, stop.
    localparam int unsigned FRAME_LEN = 10;
    localparam int unsigned DATA_LEN  = 7;
    localparam int unsigned POS_W     = 4;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    // Configuration register map.
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_PARITY_ODD = '0;

    // ASCII bases for the hex digit.
    localparam logic [DATA_LEN-1:0] ASCII_ZERO   = 7'h30;
    localparam logic [DATA_LEN-1:0] ASCII_A_BASE = 7'h37;

    // One result item.
    typedef struct packed {
        logic [1:0]          column_select;
        logic                carrier_on;
        logic                frame_active;
        logic                key_valid;
        logic [DATA_LEN-1:0] key_char;
    } t_result;

    // Key number to ASCII hex digit.
    function automatic logic [DATA_LEN-1:0] hex_digit(input logic [3:0] k);
        logic [DATA_LEN-1:0] kx;
        kx = {3'b000, k};
        return (k < 4'd10) ? (ASCII_ZERO + kx) : (ASCII_A_BASE + kx);
    endfunction

endpackage

@@ src/keypad_scan_ir_frame_tx.sv @@
// Keypad scanner with an infrared frame transmitter.
// Input channel (i_in_valid / o_in_ready) carries ticks: a scan tick
// (i_kind = 0) with the row levels of the driven column, or a bit tick
// (i_kind = 1) that sends one frame bit. Every accepted tick yields exactly
// one result on the output channel (o_out_valid / i_out_ready): the column
// to drive next, carrier level, frame activity and any newly pressed key.
// A result appears in the cycle after its tick is accepted. The state update and
// the result are computed in a single pass of logic into the result register,
// so one tick per cycle is accepted while the receiver keeps taking results.
// When the receiver stalls, the result register holds its transfer and the
// input channel stops accepting until that result is taken.
// The APB port holds one register, parity_odd, at byte address 0; pready is
// always high and writes complete in the access cycle.
// Synchronous active-low reset clears all key marks, sets column 0, stops any
// frame, turns the carrier off, empties the result register and sets
// parity_odd to odd.
module keypad_scan_ir_frame_tx
    import kpir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Tick input channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [3:0]            i_row_levels,
    // Result output channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_column_select,
    output logic                  o_carrier_on,
    output logic                  o_frame_active,
    output logic                  o_key_valid,
    output logic [DATA_LEN-1:0]   o_key_char,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                r_parity_odd;
    logic [15:0]         r_key_pressed, n_key_pressed;
    logic [1:0]          r_scan_column, n_scan_column;
    logic [FRAME_LEN-1:0] r_frame_bits, n_frame_bits;
    logic [POS_W-1:0]    r_bit_position, n_bit_position;
    logic                r_sending, n_sending;
    logic                r_carrier, n_carrier;
    logic                r_out_valid;
    t_result             r_result, n_result;

    logic                in_xfer;
    logic                cfg_write;
    logic                found;
    logic [DATA_LEN-1:0] found_char;
    logic                parity;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    // Configuration register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1:2] == REG_PARITY_ODD);
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_PARITY_ODD)
                       ? {31'd0, r_parity_odd} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity_odd <= 1'b1;
        end else if (cfg_write) begin
            r_parity_odd <= pwdata[0];
        end
    end

    // Scan the driven column; the highest new row sets the character.
    always_comb begin
        n_key_pressed = r_key_pressed;
        found         = 1'b0;
        found_char    = '0;
        for (int r = 0; r < 4; r++) begin
            if (!i_row_levels[r]) begin
                if (!r_key_pressed[{r[1:0], r_scan_column}]) begin
                    n_key_pressed[{r[1:0], r_scan_column}] = 1'b1;
                    found      = 1'b1;
                    found_char = hex_digit({r[1:0], r_scan_column});
                end
            end else begin
                n_key_pressed[{r[1:0], r_scan_column}] = 1'b0;
            end
        end
    end

    assign parity = (^found_char) ^ r_parity_odd;

    // Next state of the scanner and the frame sender.
    always_comb begin
        n_scan_column  = r_scan_column;
        n_frame_bits   = r_frame_bits;
        n_bit_position = r_bit_position;
        n_sending      = r_sending;
        n_carrier      = r_carrier;
        if (i_kind == KIND_SCAN) begin
            n_scan_column = r_scan_column + 2'd1;
            if (found) begin
                n_frame_bits   = {1'b1, parity, found_char, 1'b0};
                n_bit_position = '0;
                n_sending      = 1'b1;
            end
        end else if (r_sending) begin
            if (r_bit_position <= LAST_POS) begin
                n_carrier = !r_frame_bits[r_bit_position];
            end else begin
                n_carrier = 1'b0;
            end
            n_bit_position = r_bit_position + POS_W'(1);
            if (r_bit_position >= LAST_POS) begin
                n_sending = 1'b0;
            end
        end
    end

    // Result of this tick.
    always_comb begin
        n_result.column_select = n_scan_column;
        n_result.carrier_on    = n_carrier;
        n_result.frame_active  = n_sending;
        n_result.key_valid     = (i_kind == KIND_SCAN) && found;
        n_result.key_char      = (i_kind == KIND_SCAN) ? found_char : '0;
    end

    // State registers, updated on each accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pressed  <= '0;
            r_scan_column  <= '0;
            r_frame_bits   <= '0;
            r_bit_position <= '0;
            r_sending      <= 1'b0;
            r_carrier      <= 1'b0;
        end else if (in_xfer) begin
            r_key_pressed  <= (i_kind == KIND_SCAN) ? n_key_pressed : r_key_pressed;
            r_scan_column  <= n_scan_column;
            r_frame_bits   <= n_frame_bits;
            r_bit_position <= n_bit_position;
            r_sending      <= n_sending;
            r_carrier      <= n_carrier;
        end
    end

    // Output register; holds its transfer while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_column_select = r_result.column_select;
    assign o_carrier_on    = r_result.carrier_on;
    assign o_frame_active  = r_result.frame_active;
    assign o_key_valid     = r_result.key_valid;
    assign o_key_char      = r_result.key_char;

    // A frame in flight never points past its stop bit.
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sending |-> (r_bit_position <= LAST_POS))
        else $error("bit position beyond stop bit while sending");

    // An accepted scan tick moves to the next column.
    a_column_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_kind == KIND_SCAN)) |=>
        (r_scan_column == $past(r_scan_column) + 2'd1))
        else $error("scan column did not advance");

    // A reported key always starts a fresh frame.
    a_key_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.key_valid) |->
        (r_sending || (r_result.key_char == '0)) && r_result.frame_active)
        else $error("new key without an active frame");

    // The character is zero exactly when no key is reported.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.key_valid == (r_result.key_char != '0)))
        else $error("key character disagrees with key flag");

    // A bit tick leaves the key marks alone.
    a_bit_keeps_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_kind == KIND_BIT)) |=> $stable(r_key_pressed))
        else $error("key marks changed on a bit tick");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import kpir_pkg::*;

    localparam logic [DATA_LEN-1:0] ASCII_UPPER_A = 7'h41;
    localparam int HOLD_CYCLES = 400;

    // One tick as offered on the input channel.
    typedef struct packed {
        logic       kind;
        logic [3:0] rows;
    } t_tick;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  kind = KIND_SCAN;
    logic [3:0]            row_levels = 4'hF;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            column_select;
    logic                  carrier_on;
    logic                  frame_active;
    logic                  key_valid;
    logic [DATA_LEN-1:0]   key_char;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Ticks waiting to be offered and results owed by the block.
    t_tick   pending_ticks[$];
    t_result results_due[$];

    // Own copy of the block state and its parity register.
    logic       key_marks[16];
    logic [1:0] col_now;
    logic [9:0] frame_word;
    logic [3:0] frame_pos;
    logic       frame_busy;
    logic       carrier;
    logic       parity_odd_cfg = 1'b1;

    // Idle rates in percent, the receiver hold-off and the error count.
    int sender_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int fail_count = 0;

    // Stimulus-side tracking of the scanned column and of held keys.
    logic [1:0] gen_col = 2'd0;
    logic [3:0] held_rows[4] = '{4'hF, 4'hF, 4'hF, 4'hF};

    keypad_scan_ir_frame_tx u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind),
        .i_row_levels    (row_levels),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_column_select (column_select),
        .o_carrier_on    (carrier_on),
        .o_frame_active  (frame_active),
        .o_key_valid     (key_valid),
        .o_key_char      (key_char),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 clk = ~clk;

    // Applies one tick to the local state and returns the result it should produce.
    function automatic t_result scan_and_send(input logic tk, input logic [3:0] rows);
        t_result    res;
        logic [3:0] key;
        logic       par;
        res = '0;
        if (tk == KIND_SCAN) begin
            for (int r = 0; r < 4; r++) begin
                key = {r[1:0], col_now};
                if (!rows[r]) begin
                    // Only a key that was not already marked counts; higher rows win.
                    if (!key_marks[key]) begin
                        key_marks[key] = 1'b1;
                        res.key_valid = 1'b1;
                        res.key_char = (key < 4'd10) ? ASCII_ZERO + 7'(key)
                                                     : ASCII_UPPER_A + 7'(key) - 7'd10;
                    end
                end else begin
                    key_marks[key] = 1'b0;
                end
            end
            // A new press restarts the frame; the carrier waits for the next bit tick.
            if (res.key_valid) begin
                par = (^res.key_char) ^ parity_odd_cfg;
                frame_word = {1'b1, par, res.key_char, 1'b0};
                frame_pos = '0;
                frame_busy = 1'b1;
            end
            col_now = col_now + 2'd1;
        end else if (frame_busy) begin
            carrier = ~frame_word[frame_pos];
            if (frame_pos == LAST_POS) begin
                frame_busy = 1'b0;
            end
            frame_pos = frame_pos + 4'd1;
        end
        res.column_select = col_now;
        res.carrier_on = carrier;
        res.frame_active = frame_busy;
        return res;
    endfunction

    // Driver: predicts each accepted tick and offers the next pending one.
    always @(posedge clk) begin : drive_proc
        t_tick nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            foreach (key_marks[i]) key_marks[i] = 1'b0;
            col_now = '0;
            frame_word = '0;
            frame_pos = '0;
            frame_busy = 1'b0;
            carrier = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                results_due.push_back(scan_and_send(kind, row_levels));
            end
            if (!in_valid || in_ready) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    kind <= nxt.kind;
                    row_levels <= nxt.rows;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here and requested from the stimulus.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_taken + 1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: checks every result transfer against the oldest owed result.
    always @(posedge clk) begin : check_proc
        t_result got;
        t_result want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got = {column_select, carrier_on, frame_active, key_valid, key_char};
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Unexpected result at %0t: %p", $realtime, got);
                    end
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Mismatch at %0t: expected %p, got %p",
                                     $realtime, want, got);
                        end
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Queues one tick and follows the column the block will be driving.
    task automatic add_tick(input logic tk, input logic [3:0] rows);
        pending_ticks.push_back('{kind: tk, rows: rows});
        if (tk == KIND_SCAN) begin
            gen_col = gen_col + 2'd1;
        end
    endtask

    // Mostly held key patterns scanned in order with bit ticks between, plus noise.
    task automatic add_random_ticks(input int n);
        int c;
        int pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8) begin
                c = $urandom_range(3);
                for (int r = 0; r < 4; r++) begin
                    held_rows[c][r] = ($urandom_range(99) >= 20);
                end
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                add_tick(1'($urandom_range(1)), 4'($urandom_range(15)));
            end else if (pick < 55) begin
                add_tick(KIND_BIT, 4'($urandom_range(15)));
            end else begin
                add_tick(KIND_SCAN, held_rows[gen_col]);
            end
        end
    endtask

    // Waits until all ticks are taken and every owed result has arrived.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || in_valid || results_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes the parity register through a setup and an access cycle.
    task automatic write_parity(input logic odd);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PARITY_ODD, 2'b00};
        pwdata <= {31'd0, odd};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        parity_odd_cfg = odd;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stimulus: directed ticks, then random phases under changing parity and idling.
    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        sender_idle_pct = 25;
        recv_idle_pct = 74;

        // Bit tick while idle, then a whole column pressed at once.
        add_tick(KIND_BIT, 4'h0);
        add_tick(KIND_SCAN, 4'b0000);
        add_tick(KIND_SCAN, 4'hF);
        // A second press restarts the frame before any bit is sent.
        add_tick(KIND_SCAN, 4'b1110);
        // Run the frame to its stop bit; rows are ignored on bit ticks.
        for (int i = 0; i < 10; i++) begin
            add_tick(KIND_BIT, (i % 2) ? 4'h0 : 4'hF);
        end
        add_tick(KIND_BIT, 4'h5);
        add_tick(KIND_SCAN, 4'b0111);
        // Held keys do not count again, then keys are released.
        add_tick(KIND_SCAN, 4'b0000);
        add_tick(KIND_SCAN, 4'hF);
        add_tick(KIND_SCAN, 4'hF);
        for (int i = 0; i < 3; i++) begin
            add_tick(KIND_BIT, 4'hA);
        end
        add_tick(KIND_SCAN, 4'b0111);
        add_tick(KIND_SCAN, 4'hF);
        add_random_ticks(400);
        wait_drained();

        write_parity(1'b0);
        add_random_ticks(400);
        wait_drained();

        sender_idle_pct = 74;
        recv_idle_pct = 25;
        write_parity(1'b1);
        add_random_ticks(400);
        wait_drained();

        // No idling; the receiver holds off while the sender keeps offering.
        sender_idle_pct = 0;
        recv_idle_pct = 0;
        write_parity(1'b0);
        add_random_ticks(425);
        hold_asked++;
        wait_drained();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a stuck handshake.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
